@@ hdl/ppfrm_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the flow-rate meter.
`default_nettype none

package ppfrm_pkg;

  localparam int SAMPLES_DEF       = 8;
  localparam int TIMER_BITS_DEF    = 32;
  localparam int RPM_FRAC_BITS_DEF = 8;

  localparam int MINUTE_US_W       = 26;
  localparam logic [MINUTE_US_W-1:0] MINUTE_US = 26'd60000000;

  localparam int CMD_W  = 3;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DECAY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  localparam logic [CFG_AW-1:0] CFG_LEVEL_MODE = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DECAY_TIME = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_LOWER_RPM  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_UPPER_RPM  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PPR        = 3'd4;

  localparam logic [31:0] DECAY_TIME_RST = 32'd1000000;
  localparam logic [31:0] LOWER_RPM_RST  = 32'd0;
  localparam logic [31:0] UPPER_RPM_RST  = 32'hFFFF_FFFF;
  localparam logic [7:0]  PPR_RST        = 8'd1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_den;
    logic div_start_rate;
    logic take_sample;
    logic ring_read;
    logic ring_update;
    logic div_start_avg;
    logic take_avg;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rate;
    logic need_push;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/pulse_period_flow_rate_meter_unit.sv @@
// Top level of the pulse-period flow-rate meter.
// Tick, stop, clear, decay checks without a push, zero periods: no division; the result is
// loaded into the output register in S_FINISH and the next transaction is accepted in S_IDLE.
// A counted edge with a non-zero period on a running timer does two divisions on one shared
// restoring divider (one bit per cycle, DIV_W = max(26 + RPM_FRAC_BITS, 32 + log2 SAMPLES) bits);
// a decay push runs one. One transaction in flight, held while the output register is full and
// m_axis_tready is low; rst_ni clears timer, counters, ring valid bits and registers.
`default_nettype none

module pulse_period_flow_rate_meter_unit
  import ppfrm_pkg::*;
#(
  parameter int SAMPLES       = SAMPLES_DEF,
  parameter int TIMER_BITS    = TIMER_BITS_DEF,
  parameter int RPM_FRAC_BITS = RPM_FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [0] pin_level
  input  wire logic [2:0]        s_axis_tuser,   // [2:0] cmd
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [55:0]            m_axis_tdata    // [15:0] pulse_count, [47:16] flow_rpm,
                                                 // [51:48] filled_samples, [52] timer_running
);

  ctrl_cmd_t   ctrl_cmd;
  dp_status_t  dp_status;
  logic [15:0] pulse_count;
  logic [31:0] flow_rpm;
  logic [3:0]  filled_samples;
  logic        timer_running;

  ppfrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  ppfrm_dp #(
    .SAMPLES       (SAMPLES),
    .TIMER_BITS    (TIMER_BITS),
    .RPM_FRAC_BITS (RPM_FRAC_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_cmd_i             (s_axis_tuser),
    .in_pin_level_i       (s_axis_tdata[0]),
    .cmd_i                (ctrl_cmd),
    .status_o             (dp_status),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_pulse_count_o    (pulse_count),
    .out_flow_rpm_o       (flow_rpm),
    .out_filled_samples_o (filled_samples),
    .out_timer_running_o  (timer_running)
  );

  assign m_axis_tdata = {3'b000, timer_running, filled_samples, flow_rpm, pulse_count};

endmodule

`default_nettype wire

@@ hdl/ppfrm_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ppfrm_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   den_ext;
  logic             ge;
  logic [DEN_W:0]   rem_nx;

  assign rem_sh  = {rem_q, quot_q[NUM_W-1]};
  assign den_ext = {1'b0, den_q};
  assign ge      = (rem_sh >= den_ext);
  assign rem_nx  = ge ? (rem_sh - den_ext) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], ge};
      rem_q  <= rem_nx[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ hdl/ppfrm_ctrl.sv @@
// Sequencing state machine of the flow-rate meter.
`default_nettype none

module ppfrm_ctrl
  import ppfrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE       = 4'd0;
  localparam logic [ST_W-1:0] S_EXEC       = 4'd1;
  localparam logic [ST_W-1:0] S_MUL        = 4'd2;
  localparam logic [ST_W-1:0] S_DIV1_START = 4'd3;
  localparam logic [ST_W-1:0] S_DIV1_WAIT  = 4'd4;
  localparam logic [ST_W-1:0] S_READ       = 4'd5;
  localparam logic [ST_W-1:0] S_UPDATE     = 4'd6;
  localparam logic [ST_W-1:0] S_DIV2_START = 4'd7;
  localparam logic [ST_W-1:0] S_DIV2_WAIT  = 4'd8;
  localparam logic [ST_W-1:0] S_FINISH     = 4'd9;

  logic [ST_W-1:0] state_q;
  logic [ST_W-1:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.need_rate) begin
          state_d = S_MUL;
        end else if (status_i.need_push) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MUL: begin
        cmd_o.load_den = 1'b1;
        state_d        = S_DIV1_START;
      end
      S_DIV1_START: begin
        cmd_o.div_start_rate = 1'b1;
        state_d              = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_sample = 1'b1;
          state_d           = S_READ;
        end
      end
      S_READ: begin
        cmd_o.ring_read = 1'b1;
        state_d         = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.ring_update = 1'b1;
        state_d           = S_DIV2_START;
      end
      S_DIV2_START: begin
        cmd_o.div_start_avg = 1'b1;
        state_d             = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_avg = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ppfrm_dp.sv @@
// Datapath of the flow-rate meter: timer, sample ring, divider and output register.
`default_nettype none

module ppfrm_dp
  import ppfrm_pkg::*;
#(
  parameter int SAMPLES       = SAMPLES_DEF,
  parameter int TIMER_BITS    = TIMER_BITS_DEF,
  parameter int RPM_FRAC_BITS = RPM_FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i,
  input  wire logic [CMD_W-1:0]  in_cmd_i,
  input  wire logic              in_pin_level_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_pulse_count_o,
  output logic [31:0]            out_flow_rpm_o,
  output logic [3:0]             out_filled_samples_o,
  output logic                   out_timer_running_o
);

  localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int FILL_W = $clog2(SAMPLES + 1);
  localparam int SUM_W  = 32 + $clog2(SAMPLES);
  localparam int NUM_W  = MINUTE_US_W + RPM_FRAC_BITS;
  localparam int DIV_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DEN_W  = TIMER_BITS + 8;
  localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(MINUTE_US) << RPM_FRAC_BITS;

  logic                  level_mode_q;
  logic [31:0]           decay_q;
  logic [31:0]           lower_q;
  logic [31:0]           upper_q;
  logic [7:0]            ppr_q;

  logic [CMD_W-1:0]      cmd_q;
  logic                  pin_q;

  logic                  last_level_q;
  logic                  running_q;
  logic [TIMER_BITS-1:0] elapsed_q;
  logic [TIMER_BITS-1:0] period_q;
  logic [15:0]           pulses_q;
  logic [31:0]           rpm_q;
  logic [31:0]           sample_q;
  logic [DEN_W-1:0]      den_q;
  logic [IDX_W-1:0]      idx_q;
  logic [FILL_W-1:0]     fill_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SAMPLES-1:0]    valid_q;

  logic [31:0]           ring_mem [SAMPLES];
  logic [31:0]           ring_rd_q;

  logic                  out_valid_q;
  logic [15:0]           out_pulses_q;
  logic [31:0]           out_rpm_q;
  logic [3:0]            out_fill_q;
  logic                  out_running_q;

  logic                  counted;
  logic                  decay_hit;
  logic [TIMER_BITS+32:0] elapsed_ext;
  logic [TIMER_BITS+32:0] decay_ext;
  logic [7:0]            ppr_eff;
  logic [31:0]           old_sample;
  logic                  div_start;
  logic [DIV_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic [FILL_W+3:0]     fill_ext;
  logic [31:0]           zero_clamped;
  logic [31:0]           avg_clamped;

  function automatic logic [31:0] clamp_rpm(input logic [31:0] v, input logic [31:0] lo,
                                            input logic [31:0] hi);
    logic [31:0] r;
    priority if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign counted     = (cmd_q == CMD_EDGE) && (!level_mode_q || (pin_q && !last_level_q));
  assign elapsed_ext = {{33{1'b0}}, elapsed_q};
  assign decay_ext   = {{(TIMER_BITS + 1){1'b0}}, decay_q};
  assign decay_hit   = (cmd_q == CMD_DECAY) && running_q && (elapsed_ext >= decay_ext);
  assign ppr_eff     = (ppr_q == 8'd0) ? 8'd1 : ppr_q;
  assign old_sample  = valid_q[idx_q] ? ring_rd_q : 32'd0;
  assign zero_clamped = clamp_rpm(32'd0, lower_q, upper_q);
  assign avg_clamped  = clamp_rpm(div_quot[31:0], lower_q, upper_q);
  assign fill_ext    = {4'b0000, fill_q};

  assign status_o.need_rate = counted && running_q && (elapsed_q != '0);
  assign status_o.need_push = decay_hit;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign div_start = cmd_i.div_start_rate || cmd_i.div_start_avg;
  assign div_num   = cmd_i.div_start_rate ? DIV_W'(RATE_NUM) : DIV_W'(sum_q);
  assign div_den   = cmd_i.div_start_rate ? den_q : DEN_W'(fill_q);

  ppfrm_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_mode_q <= 1'b1;
      decay_q      <= DECAY_TIME_RST;
      lower_q      <= LOWER_RPM_RST;
      upper_q      <= UPPER_RPM_RST;
      ppr_q        <= PPR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LEVEL_MODE: level_mode_q <= cfg_wdata_i[0];
        CFG_DECAY_TIME: decay_q      <= cfg_wdata_i;
        CFG_LOWER_RPM:  lower_q      <= cfg_wdata_i;
        CFG_UPPER_RPM:  upper_q      <= cfg_wdata_i;
        CFG_PPR:        ppr_q        <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_cmd_i;
      pin_q <= in_pin_level_i;
    end
    if (cmd_i.exec) begin
      period_q <= elapsed_q;
    end
    if (cmd_i.load_den) begin
      den_q <= DEN_W'(period_q) * DEN_W'(ppr_eff);
    end
    if (cmd_i.exec) begin
      sample_q <= 32'd0;
    end else if (cmd_i.take_sample) begin
      sample_q <= ((div_quot >> 32) != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_update) begin
      ring_mem[idx_q] <= sample_q;
    end
    if (cmd_i.ring_read) begin
      ring_rd_q <= ring_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      running_q    <= 1'b0;
      elapsed_q    <= '0;
      pulses_q     <= '0;
      rpm_q        <= '0;
      idx_q        <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      valid_q      <= '0;
    end else begin
      if (cmd_i.exec) begin
        unique case (cmd_q)
          CMD_TICK: begin
            if (running_q && (elapsed_q != '1)) begin
              elapsed_q <= elapsed_q + 1'b1;
            end
          end
          CMD_EDGE: begin
            if (level_mode_q) begin
              last_level_q <= pin_q;
            end
            if (counted) begin
              elapsed_q <= '0;
              running_q <= 1'b1;
              if (running_q) begin
                pulses_q <= pulses_q + 1'b1;
                if (elapsed_q == '0) begin
                  rpm_q <= zero_clamped;
                end
              end
            end
          end
          CMD_CLEAR: begin
            pulses_q     <= '0;
            rpm_q        <= '0;
            last_level_q <= 1'b0;
            idx_q        <= '0;
            fill_q       <= '0;
            sum_q        <= '0;
            valid_q      <= '0;
          end
          CMD_STOP: begin
            running_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.ring_update) begin
        sum_q          <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
        valid_q[idx_q] <= 1'b1;
        idx_q          <= (idx_q == IDX_W'(SAMPLES - 1)) ? '0 : idx_q + 1'b1;
        if (fill_q != FILL_W'(SAMPLES)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.take_avg) begin
        rpm_q <= avg_clamped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pulses_q  <= pulses_q;
      out_rpm_q     <= rpm_q;
      out_fill_q    <= fill_ext[3:0];
      out_running_q <= running_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_pulse_count_o    = out_pulses_q;
  assign out_flow_rpm_o       = out_rpm_q;
  assign out_filled_samples_o = out_fill_q;
  assign out_timer_running_o  = out_running_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_pulse_period_flow_rate_meter_unit.sv @@
// Self-checking testbench: random and directed pulse trains with a transaction-level meter predictor.
`timescale 1ns / 1ps

module tb_pulse_period_flow_rate_meter_unit;
  import ppfrm_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int SET_ITEMS    = 175;
  localparam int NUM_SETS     = 7;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS_DEF) - 64'd1;
  localparam longint unsigned RATE_NUM  = 64'(MINUTE_US) << RPM_FRAC_BITS_DEF;
  localparam longint unsigned U32_MAX   = 64'hFFFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic             pin;
  } meter_item_t;

  typedef struct {
    logic [15:0] pulses;
    logic [31:0] rpm;
    logic [3:0]  fill;
    logic        running;
  } meter_reading_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i    = '0;
  logic [CFG_DW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [0] pin_level
  logic [2:0]        s_axis_tuser  = '0;  // [2:0] cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;        // [15:0] pulse_count, [47:16] flow_rpm,
                                          // [51:48] filled_samples, [52] timer_running

  meter_item_t    pending_q[$];
  meter_reading_t reading_q[$];
  int             mismatches     = 0;
  int             cycles         = 0;
  int             send_gap_pct   = 0;
  int             recv_stall_pct = 0;
  int             hold_req       = 0;

  // predictor copy of registers and state
  logic        cfg_level_mode = 1'b1;
  logic [31:0] cfg_decay      = DECAY_TIME_RST;
  logic [31:0] cfg_lower      = LOWER_RPM_RST;
  logic [31:0] cfg_upper      = UPPER_RPM_RST;
  logic [7:0]  cfg_ppr        = PPR_RST;

  logic            m_last_level = 1'b0;
  logic            m_running    = 1'b0;
  longint unsigned m_elapsed    = 0;
  logic [15:0]     m_pulses     = '0;
  logic [31:0]     m_rpm        = '0;
  logic [31:0]     m_ring[SAMPLES_DEF];
  int              m_idx        = 0;
  int              m_fill       = 0;
  longint unsigned m_sum        = 0;

  pulse_period_flow_rate_meter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] limit_rpm(logic [31:0] v);
    if (v < cfg_lower) return cfg_lower;
    if (v > cfg_upper) return cfg_upper;
    return v;
  endfunction

  function automatic void ring_insert(logic [31:0] s);
    m_sum         = m_sum - m_ring[m_idx] + s;
    m_ring[m_idx] = s;
    m_idx         = (m_idx + 1) % SAMPLES_DEF;
    if (m_fill < SAMPLES_DEF) m_fill++;
    m_rpm = limit_rpm(32'(m_sum / m_fill));
  endfunction

  function automatic void clear_store();
    m_pulses     = '0;
    m_rpm        = '0;
    m_last_level = 1'b0;
    m_fill       = 0;
    m_idx        = 0;
    m_sum        = 0;
    foreach (m_ring[i]) m_ring[i] = '0;
  endfunction

  function automatic void pulse_edge();
    longint unsigned period;
    longint unsigned ppr;
    longint unsigned quot;
    if (!m_running) begin
      m_elapsed = 0;
      m_running = 1'b1;
    end else begin
      period    = m_elapsed;
      m_elapsed = 0;
      m_pulses  = m_pulses + 16'd1;
      if (period == 0) begin
        m_rpm = limit_rpm(32'd0);
      end else begin
        ppr  = (cfg_ppr == 8'd0) ? 64'd1 : 64'(cfg_ppr);
        quot = RATE_NUM / (period * ppr);
        if (quot > U32_MAX) quot = U32_MAX;
        ring_insert(quot[31:0]);
      end
    end
  endfunction

  function automatic meter_reading_t predict_reading(logic [CMD_W-1:0] cmd, logic pin);
    meter_reading_t r;
    case (cmd)
      CMD_TICK: if (m_running && m_elapsed < TIMER_MAX) m_elapsed++;
      CMD_EDGE: begin
        if (cfg_level_mode) begin
          if (pin && !m_last_level) pulse_edge();
          m_last_level = pin;
        end else begin
          pulse_edge();
        end
      end
      CMD_DECAY: if (m_running && m_elapsed >= 64'(cfg_decay)) ring_insert(32'd0);
      CMD_CLEAR: clear_store();
      CMD_STOP:  m_running = 1'b0;
      default: ;
    endcase
    r.pulses  = m_pulses;
    r.rpm     = m_rpm;
    r.fill    = m_fill[3:0];
    r.running = m_running;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
  endtask

  // sender
  always @(posedge clk_i) begin : drive_proc
    logic        offer;
    meter_item_t item;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        reading_q.push_back(predict_reading(s_axis_tuser, s_axis_tdata[0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = pending_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct;
        if (offer) begin
          item = pending_q.pop_front();
          s_axis_tdata <= {7'd0, item.pin};
          s_axis_tuser <= item.cmd;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : check_proc
    meter_reading_t exp_r;
    int             hold_left;
    int             hold_done;
    logic           rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reading_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, m_axis_tdata);
        end else begin
          exp_r = reading_q.pop_front();
          if (m_axis_tdata[15:0] !== exp_r.pulses)
            report_mismatch("pulse_count", exp_r.pulses, m_axis_tdata[15:0]);
          if (m_axis_tdata[47:16] !== exp_r.rpm)
            report_mismatch("flow_rpm", exp_r.rpm, m_axis_tdata[47:16]);
          if (m_axis_tdata[51:48] !== exp_r.fill)
            report_mismatch("filled_samples", exp_r.fill, m_axis_tdata[51:48]);
          if (m_axis_tdata[52] !== exp_r.running)
            report_mismatch("timer_running", exp_r.running, m_axis_tdata[52]);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
        rdy       = 1'b0;
      end else begin
        rdy = $urandom_range(0, 99) >= recv_stall_pct;
      end
      m_axis_tready <= rdy;
    end
  end

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic pin);
    meter_item_t it;
    it.cmd = cmd;
    it.pin = pin;
    pending_q.push_back(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || reading_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_meter(logic mode, logic [31:0] decay, logic [31:0] lower,
                               logic [31:0] upper, logic [7:0] ppr);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_LEVEL_MODE, {junk[31:1], mode});
    write_reg(CFG_DECAY_TIME, decay);
    write_reg(CFG_LOWER_RPM, lower);
    write_reg(CFG_UPPER_RPM, upper);
    write_reg(CFG_PPR, {junk[23:0], ppr});
    cfg_level_mode = mode;
    cfg_decay      = decay;
    cfg_lower      = lower;
    cfg_upper      = upper;
    cfg_ppr        = ppr;
  endtask

  // mostly tick runs closed by a sensor pulse, with some noise in between
  task automatic queue_random_items(int count);
    int added;
    int ticks;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 82) begin
        ticks = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 12);
        repeat (ticks) queue_item(CMD_TICK, 1'($urandom));
        if ($urandom_range(0, 99) < 30) begin
          queue_item(CMD_DECAY, 1'($urandom));
          added++;
        end
        if ($urandom_range(0, 99) < 75) begin
          queue_item(CMD_EDGE, 1'b0);
          added++;
        end
        queue_item(CMD_EDGE, $urandom_range(0, 9) != 0);
        added += ticks + 1;
      end else begin
        queue_item(3'($urandom_range(0, 7)), 1'($urandom));
        added++;
      end
    end
  endtask

  initial begin : stim_proc
    foreach (m_ring[i]) m_ring[i] = '0;
    send_gap_pct   = 16;
    recv_stall_pct = 70;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(CMD_TICK, 1'b1);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_TICK, 1'b0);
    queue_item(CMD_TICK, 1'b0);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_EDGE, 1'b0);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_EDGE, 1'b0);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_TICK, 1'b1);
    queue_item(CMD_EDGE, 1'b0);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_DECAY, 1'b0);
    queue_item(CMD_STOP, 1'b1);
    queue_item(CMD_TICK, 1'b0);
    queue_item(CMD_DECAY, 1'b1);
    queue_item(CMD_SPARE5, 1'b1);
    queue_item(CMD_SPARE6, 1'b0);
    queue_item(CMD_SPARE7, 1'b1);
    queue_item(CMD_EDGE, 1'b0);
    queue_item(CMD_EDGE, 1'b1);
    queue_item(CMD_CLEAR, 1'b0);
    queue_item(CMD_TICK, 1'b0);
    queue_item(CMD_EDGE, 1'b0);
    queue_item(CMD_EDGE, 1'b1);

    for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
      wait_drained();
      case (set_no)
        1: program_meter(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0);
        2: program_meter(1'b1, $urandom_range(0, 30), $urandom_range(0, 1 << 24),
                         $urandom_range(1 << 24, 1 << 28), $urandom_range(1, 255));
        3: program_meter(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd255);
        5: program_meter(1'b1, 32'd3, 32'd0, 32'd0, 8'd1);
        4, 6: program_meter(1'($urandom), $urandom_range(0, 40), $urandom_range(0, 1 << 26),
                            $urandom, $urandom_range(0, 255));
        default: ;
      endcase
      if (set_no < 3) begin
        send_gap_pct   = 16;
        recv_stall_pct = 70;
      end else if (set_no < 5) begin
        send_gap_pct   = 70;
        recv_stall_pct = 16;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      queue_random_items(SET_ITEMS);
      if (set_no == 2 || set_no == 5) hold_req++;
    end

    wait_drained();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
